/* src/c3sk_pkg.sv */
// Shared types and constants for the 3x3 RGB convolution block.
package c3sk_pkg;

  localparam int PIX_W   = 24;
  localparam int ENTRY_W = 2 * PIX_W;
  localparam int LANES   = 3;

  typedef logic [7:0] chan_t;
  typedef chan_t [8:0] win_t;

  localparam logic [2:0] MODE_SOBEL_LEFT = 3'd1;
  localparam logic [2:0] MODE_IDENTITY   = 3'd2;
  localparam logic [2:0] MODE_OUTLINE    = 3'd3;
  localparam logic [2:0] MODE_SHARPEN    = 3'd4;
  localparam logic [2:0] MODE_SOBEL_TOP  = 3'd5;

  localparam logic [1:0] REG_FILTER_MODE  = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef struct packed {
    logic       emit;
    logic       frame_last;
    logic [8:0] row;
    logic [8:0] col;
  } ctrl_t;

  function automatic logic mode_is_valid(input logic [2:0] mode);
    return (mode == MODE_SOBEL_LEFT) || (mode == MODE_IDENTITY) ||
           (mode == MODE_OUTLINE) || (mode == MODE_SHARPEN) ||
           (mode == MODE_SOBEL_TOP);
  endfunction

endpackage

/* src/c3sk_line_store.sv */
// Two-row line store: one entry per column holds the upper and middle row pixels.
module c3sk_line_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [c3sk_pkg::ENTRY_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [c3sk_pkg::ENTRY_W-1:0] wr_data
);

  logic [c3sk_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/c3sk_lane.sv */
// One color channel lane: applies the selected 3x3 kernel modulo 256, or gives 8'hFF for an invalid mode.
module c3sk_lane (
  input  logic [2:0]      mode,
  input  c3sk_pkg::win_t  win,
  output c3sk_pkg::chan_t result
);

  c3sk_pkg::chan_t p0, p1, p2, p3, p4, p5, p6, p7, p8;

  assign p0 = win[0];
  assign p1 = win[1];
  assign p2 = win[2];
  assign p3 = win[3];
  assign p4 = win[4];
  assign p5 = win[5];
  assign p6 = win[6];
  assign p7 = win[7];
  assign p8 = win[8];

  always_comb begin
    unique case (mode)
      c3sk_pkg::MODE_SOBEL_LEFT: begin
        result = p0 - p2 + {p3[6:0], 1'b0} - {p5[6:0], 1'b0} + p6 - p8;
      end
      c3sk_pkg::MODE_IDENTITY: begin
        result = p4;
      end
      c3sk_pkg::MODE_OUTLINE: begin
        result = {p4[4:0], 3'b000} - p0 - p1 - p2 - p3 - p5 - p6 - p7 - p8;
      end
      c3sk_pkg::MODE_SHARPEN: begin
        result = p4 + {p4[5:0], 2'b00} - p1 - p3 - p5 - p7;
      end
      c3sk_pkg::MODE_SOBEL_TOP: begin
        result = p0 + {p1[6:0], 1'b0} + p2 - p6 - {p7[6:0], 1'b0} - p8;
      end
      default: begin
        result = 8'hFF;
      end
    endcase
  end

endmodule

/* src/conv3x3_rgb_selectable_kernel.sv */
// Top level of the 3x3 RGB convolution with selectable kernel.
//
// Pixels enter in raster order on in_valid/in_ready, one request per pixel,
// with the three channel bytes on pixel_ch0..pixel_ch2. For every interior
// centre pixel a result leaves on out_valid/out_ready when its bottom-right
// neighbour has been taken; border pixels produce no result.
// Configuration: cfg_wen writes cfg_data into register cfg_index
// (0 filter_mode, 1 image_width, 2 image_height); write only while idle.
// Throughput is one pixel per cycle while the receiver does not stall: the line
// store has one read and one write port and each channel has its own kernel lane.
// The accepting edge starts the line store read and loads the middle stage;
// when the middle stage advances, the kernel lanes are loaded into the output register.
// Reset clears the counters, window and handshake state and sets the mode to
// invalid and the size to 512 x 512; the line store is not cleared.
// When the receiver stalls, the output register holds its result and the
// middle stage holds one pixel; in_ready drops only when both are full.
module conv3x3_rgb_selectable_kernel #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] pixel_ch0,
  input  logic [7:0] pixel_ch1,
  input  logic [7:0] pixel_ch2,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [8:0] out_row,
  output logic [8:0] out_col,
  output logic [7:0] out_ch0,
  output logic [7:0] out_ch1,
  output logic [7:0] out_ch2,
  output logic       mode_error,
  output logic       frame_last
);

  localparam int CW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WLW = ($clog2(MAX_WIDTH + 1) > 10) ? $clog2(MAX_WIDTH + 1) : 10;
  localparam int HLW = ($clog2(MAX_HEIGHT + 1) > 10) ? $clog2(MAX_HEIGHT + 1) : 10;
  localparam int PW  = c3sk_pkg::PIX_W;

  logic [2:0] filter_mode;
  logic [9:0] image_width;
  logic [9:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= 3'd0;
      image_width  <= 10'd512;
      image_height <= 10'd512;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        c3sk_pkg::REG_FILTER_MODE:  filter_mode  <= cfg_data[2:0];
        c3sk_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        c3sk_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic [WLW-1:0] width_raw, width_lim;
  logic [HLW-1:0] height_raw, height_lim;

  assign width_raw  = WLW'(image_width);
  assign height_raw = HLW'(image_height);

  always_comb begin
    priority if (width_raw < WLW'(3)) begin
      width_lim = WLW'(3);
    end else if (width_raw > WLW'(MAX_WIDTH)) begin
      width_lim = WLW'(MAX_WIDTH);
    end else begin
      width_lim = width_raw;
    end
    priority if (height_raw < HLW'(3)) begin
      height_lim = HLW'(3);
    end else if (height_raw > HLW'(MAX_HEIGHT)) begin
      height_lim = HLW'(MAX_HEIGHT);
    end else begin
      height_lim = height_raw;
    end
  end

  logic [CW-1:0] col_count, col_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic          accept;
  logic          row_end, frame_end;
  c3sk_pkg::ctrl_t ctrl_in;
  logic [RW-1:0] row_m1;
  logic [CW-1:0] col_m1;

  assign accept    = in_valid && in_ready;
  assign row_end   = (WLW'(col_count) + WLW'(1)) >= width_lim;
  assign frame_end = row_end && ((HLW'(row_count) + HLW'(1)) >= height_lim);
  assign row_m1    = row_count - RW'(1);
  assign col_m1    = col_count - CW'(1);

  always_comb begin
    ctrl_in.emit       = (HLW'(row_count) >= HLW'(2)) && (WLW'(col_count) >= WLW'(2)) &&
                         (WLW'(col_count) < width_lim) && (HLW'(row_count) < height_lim);
    ctrl_in.frame_last = frame_end;
    ctrl_in.row        = 9'(row_m1);
    ctrl_in.col        = 9'(col_m1);
    if (row_end) begin
      col_count_next = '0;
      row_count_next = frame_end ? '0 : row_count + RW'(1);
    end else begin
      col_count_next = col_count + CW'(1);
      row_count_next = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  logic            s1_valid;
  c3sk_pkg::ctrl_t s1_ctrl;
  logic [PW-1:0]   s1_px;
  logic [CW-1:0]   s1_addr;
  logic            s1_adv, s1_fire, load;
  logic [c3sk_pkg::ENTRY_W-1:0] store_rd, store_wr;
  logic [PW-1:0]   up, mid;

  assign s1_adv   = !s1_ctrl.emit || !out_valid || out_ready;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_ready = !s1_valid || s1_adv;
  assign load     = s1_fire && s1_ctrl.emit;
  assign up       = store_rd[c3sk_pkg::ENTRY_W-1:PW];
  assign mid      = store_rd[PW-1:0];
  assign store_wr = {mid, s1_px};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl <= ctrl_in;
      s1_px   <= {pixel_ch2, pixel_ch1, pixel_ch0};
      s1_addr <= col_count;
    end
  end

  c3sk_line_store #(
    .DEPTH(MAX_WIDTH),
    .AW   (CW)
  ) u_line_store (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(col_count),
    .rd_data(store_rd),
    .wr_en  (s1_fire),
    .wr_addr(s1_addr),
    .wr_data(store_wr)
  );

  logic [PW-1:0] win_left [3];
  logic [PW-1:0] win_mid  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_left[i] <= '0;
        win_mid[i]  <= '0;
      end
    end else if (s1_fire) begin
      for (int i = 0; i < 3; i++) begin
        win_left[i] <= win_mid[i];
      end
      win_mid[0] <= up;
      win_mid[1] <= mid;
      win_mid[2] <= s1_px;
    end
  end

  c3sk_pkg::win_t  lane_win [c3sk_pkg::LANES];
  c3sk_pkg::chan_t lane_res [c3sk_pkg::LANES];

  for (genvar k = 0; k < c3sk_pkg::LANES; k++) begin : g_lane
    assign lane_win[k][0] = win_left[0][8*k +: 8];
    assign lane_win[k][1] = win_mid[0][8*k +: 8];
    assign lane_win[k][2] = up[8*k +: 8];
    assign lane_win[k][3] = win_left[1][8*k +: 8];
    assign lane_win[k][4] = win_mid[1][8*k +: 8];
    assign lane_win[k][5] = mid[8*k +: 8];
    assign lane_win[k][6] = win_left[2][8*k +: 8];
    assign lane_win[k][7] = win_mid[2][8*k +: 8];
    assign lane_win[k][8] = s1_px[8*k +: 8];

    c3sk_lane u_lane (
      .mode  (filter_mode),
      .win   (lane_win[k]),
      .result(lane_res[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row    <= s1_ctrl.row;
      out_col    <= s1_ctrl.col;
      out_ch0    <= lane_res[0];
      out_ch1    <= lane_res[1];
      out_ch2    <= lane_res[2];
      mode_error <= !c3sk_pkg::mode_is_valid(filter_mode);
      frame_last <= s1_ctrl.frame_last;
    end
  end

endmodule

/* sim/tb.sv */
// Testbench for the 3x3 RGB convolution block: self-checking with a kernel tracker.
`timescale 1ns / 1ps

module tb;

  localparam int DIM_MAX = 512;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [2:0] MODE_OFF = 3'd0;
  localparam logic [2:0] MODE_RESERVED = 3'd7;

  typedef struct packed {
    logic [8:0]      row;
    logic [8:0]      col;
    c3sk_pkg::chan_t ch0;
    c3sk_pkg::chan_t ch1;
    c3sk_pkg::chan_t ch2;
    logic            err;
    logic            last;
  } conv_result_t;

  class conv_tracker;
    logic [23:0]  upper_line[DIM_MAX];
    logic [23:0]  middle_line[DIM_MAX];
    logic [23:0]  win[6];
    logic [23:0]  taps[9];
    int unsigned  col;
    int unsigned  row;
    logic [2:0]   mode;
    logic [9:0]   width_reg;
    logic [9:0]   height_reg;
    conv_result_t filtered_due[$];
    int unsigned  errors;

    function new();
      for (int i = 0; i < DIM_MAX; i++) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
      col = 0;
      row = 0;
      mode = MODE_OFF;
      width_reg = 10'd512;
      height_reg = 10'd512;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [9:0] v);
      case (idx)
        c3sk_pkg::REG_FILTER_MODE:  mode = v[2:0];
        c3sk_pkg::REG_IMAGE_WIDTH:  width_reg = v;
        c3sk_pkg::REG_IMAGE_HEIGHT: height_reg = v;
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(logic [9:0] v);
      if (v < 3) return 3;
      if (v > DIM_MAX) return DIM_MAX;
      return v;
    endfunction

    function c3sk_pkg::chan_t lane_sum(int ch);
      int wt[9];
      int acc;
      case (mode)
        c3sk_pkg::MODE_SOBEL_LEFT: wt = '{1, 0, -1, 2, 0, -2, 1, 0, -1};
        c3sk_pkg::MODE_IDENTITY:   wt = '{0, 0, 0, 0, 1, 0, 0, 0, 0};
        c3sk_pkg::MODE_OUTLINE:    wt = '{-1, -1, -1, -1, 8, -1, -1, -1, -1};
        c3sk_pkg::MODE_SHARPEN:    wt = '{0, -1, 0, -1, 5, -1, 0, -1, 0};
        c3sk_pkg::MODE_SOBEL_TOP:  wt = '{1, 2, 1, 0, 0, 0, -1, -2, -1};
        default:                   wt = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      endcase
      acc = 0;
      for (int i = 0; i < 9; i++) acc += int'(taps[i][8*ch +: 8]) * wt[i];
      return acc[7:0];
    endfunction

    function void take_pixel(c3sk_pkg::chan_t b0, c3sk_pkg::chan_t b1,
                             c3sk_pkg::chan_t b2);
      int unsigned  w;
      int unsigned  h;
      int unsigned  ci;
      logic [23:0]  px;
      logic [23:0]  up;
      logic [23:0]  mid;
      bit           row_end;
      bit           frame_end;
      conv_result_t res;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      px = {b2, b1, b0};
      ci = (col < DIM_MAX) ? col : DIM_MAX - 1;
      up = upper_line[ci];
      mid = middle_line[ci];
      row_end = (col + 1 >= w);
      frame_end = row_end && (row + 1 >= h);
      if (row >= 2 && col >= 2 && col < w && row < h) begin
        taps = '{win[0], win[3], up, win[1], win[4], mid, win[2], win[5], px};
        res.row = 9'(row - 1);
        res.col = 9'(col - 1);
        if (mode inside {c3sk_pkg::MODE_SOBEL_LEFT, c3sk_pkg::MODE_IDENTITY,
                         c3sk_pkg::MODE_OUTLINE, c3sk_pkg::MODE_SHARPEN,
                         c3sk_pkg::MODE_SOBEL_TOP}) begin
          res.ch0 = lane_sum(0);
          res.ch1 = lane_sum(1);
          res.ch2 = lane_sum(2);
          res.err = 1'b0;
        end else begin
          res.ch0 = 8'hFF;
          res.ch1 = 8'hFF;
          res.ch2 = 8'hFF;
          res.err = 1'b1;
        end
        res.last = frame_end;
        filtered_due.push_back(res);
      end
      upper_line[ci] = mid;
      middle_line[ci] = px;
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = up;
      win[4] = mid;
      win[5] = px;
      if (row_end) begin
        col = 0;
        row = frame_end ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(conv_result_t got);
      conv_result_t want;
      if (filtered_due.size() == 0) begin
        $error("unexpected result at row %0d col %0d", got.row, got.col);
        errors++;
        return;
      end
      want = filtered_due.pop_front();
      compare("out_row", want.row, got.row);
      compare("out_col", want.col, got.col);
      compare("out_ch0", want.ch0, got.ch0);
      compare("out_ch1", want.ch1, got.ch1);
      compare("out_ch2", want.ch2, got.ch2);
      compare("mode_error", want.err, got.err);
      compare("frame_last", want.last, got.last);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wen = 1'b0;
  logic [1:0] cfg_index = c3sk_pkg::REG_FILTER_MODE;
  logic [9:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] pixel_ch0 = '0;
  logic [7:0] pixel_ch1 = '0;
  logic [7:0] pixel_ch2 = '0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [8:0] out_row;
  logic [8:0] out_col;
  logic [7:0] out_ch0;
  logic [7:0] out_ch1;
  logic [7:0] out_ch2;
  logic       mode_error;
  logic       frame_last;

  conv_tracker tracker = new();
  bit          calm = 1'b0;
  int unsigned pixels_sent = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  logic [2:0]  sweep[7] = '{c3sk_pkg::MODE_SOBEL_LEFT, c3sk_pkg::MODE_IDENTITY,
                            c3sk_pkg::MODE_OUTLINE, c3sk_pkg::MODE_SHARPEN,
                            c3sk_pkg::MODE_SOBEL_TOP, MODE_OFF, MODE_RESERVED};

  conv3x3_rgb_selectable_kernel u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_ch0  (pixel_ch0),
    .pixel_ch1  (pixel_ch1),
    .pixel_ch2  (pixel_ch2),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_ch0    (out_ch0),
    .out_ch1    (out_ch1),
    .out_ch2    (out_ch2),
    .mode_error (mode_error),
    .frame_last (frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_result('{out_row, out_col, out_ch0, out_ch1, out_ch2, mode_error,
                             frame_last});
  end

  function automatic c3sk_pkg::chan_t pick_byte(bit extremes);
    if (extremes || $urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic logic [2:0] pick_mode();
    if ($urandom_range(0, 4) == 0) return 3'($urandom_range(0, 7));
    return sweep[$urandom_range(0, 4)];
  endfunction

  task automatic load_setup(logic [2:0] m, logic [9:0] wd, logic [9:0] ht);
    cfg_wen <= 1'b1;
    cfg_index <= c3sk_pkg::REG_FILTER_MODE;
    cfg_data <= 10'(m);
    @(posedge clk);
    cfg_index <= c3sk_pkg::REG_IMAGE_WIDTH;
    cfg_data <= wd;
    @(posedge clk);
    cfg_index <= c3sk_pkg::REG_IMAGE_HEIGHT;
    cfg_data <= ht;
    @(posedge clk);
    cfg_wen <= 1'b0;
    tracker.set_reg(c3sk_pkg::REG_FILTER_MODE, 10'(m));
    tracker.set_reg(c3sk_pkg::REG_IMAGE_WIDTH, wd);
    tracker.set_reg(c3sk_pkg::REG_IMAGE_HEIGHT, ht);
  endtask

  task automatic push_pixel(bit extremes);
    c3sk_pkg::chan_t b0;
    c3sk_pkg::chan_t b1;
    c3sk_pkg::chan_t b2;
    b0 = pick_byte(extremes);
    b1 = pick_byte(extremes);
    b2 = pick_byte(extremes);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_ch0 <= b0;
    pixel_ch1 <= b1;
    pixel_ch2 <= b2;
    do @(posedge clk); while (!in_ready);
    tracker.take_pixel(b0, b1, b2);
    pixels_sent++;
  endtask

  task automatic feed(int n, bit extremes);
    for (int i = 0; i < n; i++) push_pixel(extremes);
    in_valid <= 1'b0;
  endtask

  task automatic feed_frame(bit extremes);
    do push_pixel(extremes); while (tracker.col != 0 || tracker.row != 0);
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    while (tracker.filtered_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one result row per mode in a 3-wide frame, bytes at 0 or 255
    load_setup(c3sk_pkg::MODE_SOBEL_LEFT, 10'd3, 10'd9);
    feed(6, 1'b1);
    for (int i = 0; i < 7; i++) begin
      settle();
      load_setup(sweep[i], 10'd3, 10'd9);
      feed(3, 1'b1);
    end

    // undersized height, then shrink the width down to the column counter mid-frame
    settle();
    load_setup(c3sk_pkg::MODE_OUTLINE, 10'd4, 10'd0);
    feed(11, 1'b1);
    settle();
    load_setup(c3sk_pkg::MODE_OUTLINE, 10'd2, 10'd0);
    feed_frame(1'b1);

    while (pixels_sent < 220) begin
      calm = ($urandom_range(0, 3) == 0);
      settle();
      load_setup(pick_mode(), 10'($urandom_range(0, 10)), 10'($urandom_range(0, 8)));
      feed_frame(1'b0);
    end

    // oversized width, then shrink it mid-row
    calm = 1'b0;
    settle();
    load_setup(c3sk_pkg::MODE_SOBEL_TOP, 10'd1023, 10'd3);
    feed(20, 1'b0);
    settle();
    load_setup(c3sk_pkg::MODE_SOBEL_TOP, 10'd10, 10'd3);
    feed_frame(1'b0);

    // oversized height, then shrink it down to the row counter
    settle();
    load_setup(c3sk_pkg::MODE_SHARPEN, 10'd3, 10'd1023);
    feed(15, 1'b0);
    settle();
    load_setup(c3sk_pkg::MODE_SHARPEN, 10'd3, 10'd5);
    feed_frame(1'b0);

    calm = 1'b1;
    for (int i = 0; i < 4; i++) begin
      settle();
      load_setup(pick_mode(), 10'($urandom_range(3, 9)), 10'($urandom_range(3, 7)));
      feed_frame(1'b0);
    end

    settle();
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
